[design/vmt_pkg.sv]
package vmt_pkg;

  localparam int unsigned ROOT_STEPS = 34;   // result bits of the square root
  localparam int unsigned QUO_BITS   = 33;   // quotient bits of each divider lane
  localparam int unsigned SUM_W      = 67;   // sum of four squares
  localparam int unsigned ROOT_W     = 68;   // root accumulator, holds the top trial bit
  localparam int unsigned LEN_W      = 34;
  localparam int unsigned PROD_W     = 63;
  localparam int unsigned MAG_W      = 33;

  typedef struct packed {
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] cur_z;
    logic signed [31:0] cur_w;
    logic signed [31:0] tgt_x;
    logic signed [31:0] tgt_y;
    logic signed [31:0] tgt_z;
    logic signed [31:0] tgt_w;
    logic        [30:0] max_step;
  } vmt_in_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic signed [31:0] new_w;
    logic               reached;
  } vmt_out_t;

  // Square root working state.
  typedef struct packed {
    logic [SUM_W-1:0]  num;
    logic [ROOT_W-1:0] res;
  } vmt_root_t;

  // Per-item data that rides alongside the root chain.
  typedef struct packed {
    logic [3:0][31:0]       cur;
    logic [3:0][31:0]       tgt;
    logic [3:0]             neg;
    logic [30:0]            step;
    logic [3:0][PROD_W-1:0] prod;
  } vmt_side_t;

  typedef struct packed {
    logic [3:0][31:0]         cur;
    logic [3:0][31:0]         tgt;
    logic [3:0]               neg;
    logic [30:0]              step;
    logic [LEN_W-1:0]         len;
    logic [3:0][PROD_W-1:0]   rem;
    logic [3:0][QUO_BITS-1:0] quo;
  } vmt_div_t;

endpackage

[design/vec4_move_towards.sv]
// Moves a 4-vector a bounded step toward a target. Each input word carries
// current and target points and a largest step length, all Q16.16 (the step
// unsigned Q15.16); each output word carries the moved point and a flag that
// is set when the target itself was returned. The pipeline takes one word per
// cycle unless stalled: front stages form the differences, the squares, the
// scaled steps and the sum of squares, root stages run one bit each of the
// integer square root, divider stages run one quotient bit each of four
// parallel restoring dividers, and the output register holds the result.
// The whole pipeline advances together; it holds only while a finished word
// sits in the output register and out_stall is high, and in_stall shows
// exactly that condition, so the pipeline keeps taking words while gaps
// (invalid slots) are moving toward the output.
module vec4_move_towards (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vmt_pkg::vmt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output vmt_pkg::vmt_out_t out_data
);

  localparam int unsigned RS = vmt_pkg::ROOT_STEPS;
  localparam int unsigned QB = vmt_pkg::QUO_BITS;

  // Every stage advances when the output register is free to take a word.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic               root_vld  [0:RS];
  vmt_pkg::vmt_root_t root_data [0:RS];
  vmt_pkg::vmt_side_t side_data [0:RS];

  vmt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .out_valid_r (root_vld[0]),
    .root_r      (root_data[0]),
    .side_r      (side_data[0])
  );

  // Square root: one result bit per stage, top bit first.
  for (genvar g = 0; g < RS; g++) begin : g_root
    vmt_root_stage #(.IDX(g)) u_stage (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .in_valid    (root_vld[g]),
      .in_root     (root_data[g]),
      .in_side     (side_data[g]),
      .out_valid_r (root_vld[g+1]),
      .root_r      (root_data[g+1]),
      .side_r      (side_data[g+1])
    );
  end

  // The root fits in its low bits; the scaled steps become the dividends.
  logic              div_vld  [0:QB];
  vmt_pkg::vmt_div_t div_data [0:QB];

  assign div_vld[0]       = root_vld[RS];
  assign div_data[0].cur  = side_data[RS].cur;
  assign div_data[0].tgt  = side_data[RS].tgt;
  assign div_data[0].neg  = side_data[RS].neg;
  assign div_data[0].step = side_data[RS].step;
  assign div_data[0].len  = root_data[RS].res[vmt_pkg::LEN_W-1:0];
  assign div_data[0].rem  = side_data[RS].prod;
  assign div_data[0].quo  = '0;

  // Division: one quotient bit per stage for all four lanes at once.
  for (genvar g = 0; g < QB; g++) begin : g_div
    vmt_div_stage #(.IDX(g)) u_stage (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (en),
      .in_valid    (div_vld[g]),
      .in_div      (div_data[g]),
      .out_valid_r (div_vld[g+1]),
      .div_r       (div_data[g+1])
    );
  end

  vmt_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (div_vld[QB]),
    .in_div      (div_data[QB]),
    .out_valid_r (out_valid),
    .out_r       (out_data)
  );

endmodule

[design/vmt_front.sv]
module vmt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  vmt_pkg::vmt_in_t   in_data,
  output logic               out_valid_r,
  output vmt_pkg::vmt_root_t root_r,
  output vmt_pkg::vmt_side_t side_r
);

  // Stage 1: differences and magnitudes.
  logic                             v1_r;
  logic [3:0][31:0]                 cur1_r, tgt1_r;
  logic [3:0]                       neg1_r;
  logic [3:0][vmt_pkg::MAG_W-1:0]   mag1_r;
  logic [30:0]                      step1_r;
  // Stage 2: squares and scaled steps.
  logic                             v2_r;
  vmt_pkg::vmt_side_t               side2_r;
  logic [3:0][65:0]                 sq2_r;
  // Stage 3: pair sums.
  logic                             v3_r;
  vmt_pkg::vmt_side_t               side3_r;
  logic [1:0][66:0]                 pair3_r;

  logic [3:0][31:0]                 cur_in, tgt_in;
  logic [3:0][32:0]                 diff;
  logic [3:0][vmt_pkg::MAG_W-1:0]   mag_nxt;
  logic [3:0][65:0]                 sq_nxt;
  logic [3:0][vmt_pkg::PROD_W-1:0]  prod_nxt;

  assign cur_in = {in_data.cur_w, in_data.cur_z, in_data.cur_y, in_data.cur_x};
  assign tgt_in = {in_data.tgt_w, in_data.tgt_z, in_data.tgt_y, in_data.tgt_x};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      diff[i]    = {tgt_in[i][31], tgt_in[i]} - {cur_in[i][31], cur_in[i]};
      mag_nxt[i] = diff[i][32] ? (33'd0 - diff[i]) : diff[i];
    end
  end

  // A magnitude of 2^32 has zero low bits, so each product splits into a
  // 32-bit multiply and a constant case.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sq_nxt[i]   = mag1_r[i][32] ? (66'd1 << 64)
                                  : {2'd0, {32'd0, mag1_r[i][31:0]}
                                           * {32'd0, mag1_r[i][31:0]}};
      prod_nxt[i] = mag1_r[i][32] ? {step1_r, 32'd0}
                                  : vmt_pkg::PROD_W'({32'd0, mag1_r[i][31:0]}
                                                     * {33'd0, step1_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cur1_r  <= cur_in;
      tgt1_r  <= tgt_in;
      step1_r <= in_data.max_step;
      mag1_r  <= mag_nxt;
      for (int i = 0; i < 4; i++) neg1_r[i] <= diff[i][32];

      side2_r.cur  <= cur1_r;
      side2_r.tgt  <= tgt1_r;
      side2_r.neg  <= neg1_r;
      side2_r.step <= step1_r;
      side2_r.prod <= prod_nxt;
      sq2_r        <= sq_nxt;

      side3_r    <= side2_r;
      pair3_r[0] <= {1'b0, sq2_r[0]} + {1'b0, sq2_r[1]};
      pair3_r[1] <= {1'b0, sq2_r[2]} + {1'b0, sq2_r[3]};

      side_r     <= side3_r;
      root_r.num <= pair3_r[0] + pair3_r[1];
      root_r.res <= '0;
    end
  end

endmodule

[design/vmt_root_stage.sv]
module vmt_root_stage #(
  parameter int unsigned IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  vmt_pkg::vmt_root_t in_root,
  input  vmt_pkg::vmt_side_t in_side,
  output logic               out_valid_r,
  output vmt_pkg::vmt_root_t root_r,
  output vmt_pkg::vmt_side_t side_r
);

  localparam logic [vmt_pkg::ROOT_W-1:0] TRIAL_BIT =
    vmt_pkg::ROOT_W'(1) << (2 * (vmt_pkg::ROOT_STEPS - 1 - IDX));

  logic [vmt_pkg::ROOT_W-1:0] trial;
  logic                       fits;
  vmt_pkg::vmt_root_t         root_nxt;

  always_comb begin
    trial = in_root.res + TRIAL_BIT;
    fits  = {1'b0, in_root.num} >= trial;
    if (fits) begin
      root_nxt.num = in_root.num - trial[vmt_pkg::SUM_W-1:0];
      root_nxt.res = (in_root.res >> 1) + TRIAL_BIT;
    end else begin
      root_nxt.num = in_root.num;
      root_nxt.res = in_root.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= root_nxt;
      side_r <= in_side;
    end
  end

endmodule

[design/vmt_div_stage.sv]
module vmt_div_stage #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  vmt_pkg::vmt_div_t in_div,
  output logic              out_valid_r,
  output vmt_pkg::vmt_div_t div_r
);

  localparam int unsigned SHIFT = vmt_pkg::QUO_BITS - 1 - IDX;

  logic [66:0]       dvs;
  vmt_pkg::vmt_div_t div_nxt;

  always_comb begin
    dvs     = {33'd0, in_div.len} << SHIFT;
    div_nxt = in_div;
    for (int i = 0; i < 4; i++) begin
      if ({4'd0, in_div.rem[i]} >= dvs) begin
        div_nxt.rem[i]        = in_div.rem[i] - dvs[vmt_pkg::PROD_W-1:0];
        div_nxt.quo[i][SHIFT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

endmodule

[design/vmt_back.sv]
module vmt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  vmt_pkg::vmt_div_t in_div,
  output logic              out_valid_r,
  output vmt_pkg::vmt_out_t out_r
);

  logic             reached;
  logic [3:0][31:0] res;

  always_comb begin
    reached = (in_div.len == '0) || (in_div.len <= {3'd0, in_div.step});
    for (int i = 0; i < 4; i++) begin
      if (reached) begin
        res[i] = in_div.tgt[i];
      end else if (in_div.neg[i]) begin
        res[i] = in_div.cur[i] - in_div.quo[i][31:0];
      end else begin
        res[i] = in_div.cur[i] + in_div.quo[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.new_x   <= res[0];
      out_r.new_y   <= res[1];
      out_r.new_z   <= res[2];
      out_r.new_w   <= res[3];
      out_r.reached <= reached;
    end
  end

endmodule

[design/vmt_checker.sv]
module vmt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input vmt_pkg::vmt_out_t out_data,
  input logic              out_valid,
  input logic              out_stall
);

  // The input side holds exactly when a finished word waits at the output.
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the output hold");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled word dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled word changed");

endmodule

bind vec4_move_towards vmt_checker u_vmt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

[dv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Pipeline depth of the block, counted in registers from input to output.
  localparam int PIPE_LATENCY = 72;
  // Cycles without any accepted word before the run is declared hung.
  localparam int HANG_LIMIT   = 4000;
  localparam int RANDOM_WORDS = 1450;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  vmt_pkg::vmt_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  vmt_pkg::vmt_out_t out_data;

  vec4_move_towards uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Expected moved points, oldest first.
  vmt_pkg::vmt_out_t moved_q[$];
  int       err_cnt;
  int       sent_cnt;
  int       got_cnt;
  int       reached_cnt;
  int       idle_cycles;
  // While set, the receiver ignores its random stalls and holds off solidly.
  logic     hold_off;
  // While set, the receiver never stalls (a stretch with no idling).
  logic     rx_eager;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Floor square root of a sum below 2^67, one result bit per pass.
  function automatic logic [33:0] floor_root(logic [66:0] num);
    logic [67:0] rem;
    logic [67:0] res;
    logic [67:0] bitv;
    rem  = {1'b0, num};
    res  = '0;
    bitv = 68'd1 << 66;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[33:0];
  endfunction

  // Computes the bounded move toward the target for one input word.
  function automatic vmt_pkg::vmt_out_t move_towards(vmt_pkg::vmt_in_t w);
    logic signed [31:0] cur [4];
    logic signed [31:0] tgt [4];
    logic signed [32:0] d   [4];
    logic [32:0]        mag [4];
    logic [66:0]        sumsq;
    logic [33:0]        len;
    logic [63:0]        q;
    logic signed [33:0] v   [4];
    vmt_pkg::vmt_out_t  r;
    cur = '{w.cur_x, w.cur_y, w.cur_z, w.cur_w};
    tgt = '{w.tgt_x, w.tgt_y, w.tgt_z, w.tgt_w};
    sumsq = '0;
    for (int i = 0; i < 4; i++) begin
      d[i]   = 33'(tgt[i]) - 33'(cur[i]);
      mag[i] = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
      sumsq  = sumsq + 67'(mag[i]) * 67'(mag[i]);
    end
    len = floor_root(sumsq);
    if (len == 0 || len <= 34'(w.max_step)) begin
      r = '{new_x: w.tgt_x, new_y: w.tgt_y, new_z: w.tgt_z, new_w: w.tgt_w,
            reached: 1'b1};
      return r;
    end
    for (int i = 0; i < 4; i++) begin
      q = (64'(mag[i]) * 64'(w.max_step)) / 64'(len);
      v[i] = d[i] < 0 ? 34'(cur[i]) - 34'(q) : 34'(cur[i]) + 34'(q);
    end
    r.new_x   = v[0][31:0];
    r.new_y   = v[1][31:0];
    r.new_z   = v[2][31:0];
    r.new_w   = v[3][31:0];
    r.reached = 1'b0;
    return r;
  endfunction

  // Sends one word after a random gap and waits until the block takes it.
  // in_valid stays high on return; the caller lowers it when a pause follows.
  task automatic send_word(vmt_pkg::vmt_in_t w, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(3) == 0 ? $urandom_range(16) : 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    moved_q.push_back(move_towards(w));
    sent_cnt++;
  endtask

  // Receiver: random stalls per word, plus forced hold-off and eager stretches.
  initial begin
    int wait_left;
    out_stall <= 1'b1;
    wait_left = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (rx_eager) begin
        out_stall <= 1'b0;
      end else if (wait_left > 0) begin
        out_stall <= 1'b1;
        wait_left--;
      end else begin
        out_stall <= 1'b0;
      end
      @(posedge clk);
      if (out_valid && !out_stall) begin
        wait_left = $urandom_range(2) == 0 ? $urandom_range(16) : 0;
      end
    end
  end

  // Checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    vmt_pkg::vmt_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      got_cnt++;
      if (moved_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data);
        err_cnt++;
      end else begin
        want = moved_q.pop_front();
        if (out_data.reached) reached_cnt++;
        if (out_data.new_x !== want.new_x)
          $display("%0t: new_x exp %h got %h", $time, want.new_x, out_data.new_x);
        if (out_data.new_y !== want.new_y)
          $display("%0t: new_y exp %h got %h", $time, want.new_y, out_data.new_y);
        if (out_data.new_z !== want.new_z)
          $display("%0t: new_z exp %h got %h", $time, want.new_z, out_data.new_z);
        if (out_data.new_w !== want.new_w)
          $display("%0t: new_w exp %h got %h", $time, want.new_w, out_data.new_w);
        if (out_data.reached !== want.reached)
          $display("%0t: reached exp %b got %b", $time, want.reached,
                   out_data.reached);
        if (out_data !== want) err_cnt++;
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t: no progress, %0d words still expected", $time,
                 moved_q.size());
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic vmt_pkg::vmt_in_t point_pair(logic signed [31:0] c,
                                                  logic signed [31:0] t,
                                                  logic [30:0] step);
    vmt_pkg::vmt_in_t w;
    w = '{c, c, c, c, t, t, t, t, step};
    return w;
  endfunction

  // Extremes of every field and the named special cases.
  task automatic test_corners();
    vmt_pkg::vmt_in_t w;
    // Equal points give zero length, whatever the step.
    send_word(point_pair(32'sh0001_0000, 32'sh0001_0000, 31'd0));
    send_word(point_pair(32'sh8000_0000, 32'sh8000_0000, 31'h7fff_ffff));
    // Zero step with distinct points leaves the current point.
    send_word(point_pair(32'sh0000_0000, 32'sh0005_0000, 31'd0));
    // Opposite corners of the range: widest differences and sum of squares.
    send_word(point_pair(32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff));
    send_word(point_pair(32'sh7fff_ffff, 32'sh8000_0000, 31'd1));
    send_word(point_pair(32'sh8000_0000, 32'sh7fff_ffff, 31'h0001_0000));
    // Step exactly at and just below the length.
    w = '{0, 0, 0, 0, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 31'h0005_0000};
    send_word(w);
    w.max_step = 31'h0004_ffff;
    send_word(w);
    w = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
          32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
          31'h4000_0000};
    send_word(w);
    w = '{0, 0, 0, 0, 0, 0, 0, 32'sh0000_0001, 31'd0};
    send_word(w);
    w.max_step = 31'd1;
    send_word(w);
    w = '{-1, 2, -3, 4, 5, -6, 7, -8, 31'd3};
    send_word(w);
  endtask

  // Random points; steps mostly short of the length so both outcomes occur.
  task automatic test_random(int count);
    vmt_pkg::vmt_in_t w;
    for (int n = 0; n < count; n++) begin
      w.cur_x = rand_coord(); w.cur_y = rand_coord();
      w.cur_z = rand_coord(); w.cur_w = rand_coord();
      w.tgt_x = rand_coord(); w.tgt_y = rand_coord();
      w.tgt_z = rand_coord(); w.tgt_w = rand_coord();
      case ($urandom_range(4))
        0: w.max_step = 31'($urandom_range(0, 32'h0004_0000));
        1: w.max_step = 31'(32'h7fff_ffff - $urandom_range(0, 3));
        default: w.max_step = 31'($urandom);
      endcase
      if ($urandom_range(9) == 0) begin
        w.tgt_x = w.cur_x; w.tgt_y = w.cur_y; w.tgt_z = w.cur_z; w.tgt_w = w.cur_w;
      end
      send_word(w);
    end
  endtask

  // A long receiver hold-off while the sender keeps offering words back to back,
  // so the pipeline fills and the input stalls. The pipeline holds fewer words
  // than the sender offers, so the sender finishes only after the hold ends.
  task automatic test_backpressure();
    fork
      begin
        int held;
        hold_off = 1'b1;
        held = 0;
        while (held < 3 * PIPE_LATENCY) begin
          @(posedge clk);
          held++;
        end
        hold_off = 1'b0;
      end
      begin
        for (int n = 0; n < 120; n++) begin
          send_word('{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      31'($urandom)}, 1'b1);
        end
      end
    join
  endtask

  // Both sides run flat out for a stretch.
  task automatic test_streaming();
    rx_eager = 1'b1;
    for (int n = 0; n < 150; n++) begin
      send_word('{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  31'($urandom)}, 1'b1);
    end
    rx_eager = 1'b0;
  endtask

  initial begin
    int drain;
    err_cnt     = 0;
    sent_cnt    = 0;
    got_cnt     = 0;
    reached_cnt = 0;
    hold_off    = 1'b0;
    rx_eager    = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corners();
    test_random(RANDOM_WORDS / 2);
    test_backpressure();
    test_streaming();
    test_random(RANDOM_WORDS / 2);
    in_valid <= 1'b0;

    // Drain: wait for every expected word, then run on before the summary.
    while (moved_q.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 2 * PIPE_LATENCY) begin
      @(posedge clk);
      drain++;
    end

    $display("Sent %0d words, checked %0d results, %0d of them reached the target.",
             sent_cnt, got_cnt, reached_cnt);
    $display("Corners, random points, a long output hold-off and full-rate streaming.");
    if (err_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
